FILE: src/sine_tone_burst_generator_assert.svh
// Assertion macros for the sine tone burst generator checker.
// Expects clk and rst_n in scope at the point of use.
`ifndef SINE_TONE_BURST_GENERATOR_ASSERT_SVH
`define SINE_TONE_BURST_GENERATOR_ASSERT_SVH

// Same-cycle implication, disabled in reset
`define STBG_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("stbg: same-cycle check failed");

// Next-cycle implication, disabled in reset
`define STBG_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("stbg: next-cycle check failed");

`endif

FILE: src/stbg_pkg.sv
// Shared types and constants for the sine tone burst generator.
// No dependencies; used by stbg_sine_rom and the top level.
`timescale 1ns / 1ps
`default_nettype none

package stbg_pkg;

    localparam int AMP_W      = 15;  // sine magnitude, 0..32767
    localparam int SAMPLE_W   = 16;  // signed PCM sample
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 31;

    typedef logic [AMP_W-1:0]    amp_t;
    typedef logic [SAMPLE_W-1:0] pcm_t;

    localparam amp_t AMP_MAX = 15'h7FFF;

    // Config register indexes
    localparam logic [CFG_IDX_W-1:0] REG_PHASE_STEP    = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_BURST_SAMPLES = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_FADE_SAMPLES  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_FADE_GAIN     = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_VOLUME        = 3'd4;

endpackage

`default_nettype wire

FILE: src/stbg_sine_rom.sv
// Quarter-wave sine table with quadrant folding and registered read.
// Depends on stbg_pkg; entries are built at elaboration from a fixed-point series.
`timescale 1ns / 1ps
`default_nettype none

module stbg_sine_rom
    import stbg_pkg::*;
#(
    parameter int DEPTH = 256
)
(
    input  wire logic                     clk,
    input  wire logic                     rd_en,
    input  wire logic [$clog2(DEPTH)+1:0] idx,
    output amp_t                          mag,
    output logic                          neg
);

    localparam int K_W = $clog2(DEPTH);
    localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;

    // round(32767 * sin(pi/2 * k / DEPTH)), Taylor series through x^13 in Q30
    function automatic amp_t sine_entry(input logic [63:0] k);
        logic [63:0]        x;
        logic [63:0]        x2;
        logic [63:0]        term;
        logic signed [63:0] sum;
        logic [63:0]        r;
        x    = (k * HALF_PI_Q30) / DEPTH;
        x2   = (x * x) >> 30;
        sum  = signed'(x);
        term = ((x * x2) >> 30) / 64'd6;
        sum  = sum - signed'(term);
        term = ((term * x2) >> 30) / 64'd20;
        sum  = sum + signed'(term);
        term = ((term * x2) >> 30) / 64'd42;
        sum  = sum - signed'(term);
        term = ((term * x2) >> 30) / 64'd72;
        sum  = sum + signed'(term);
        term = ((term * x2) >> 30) / 64'd110;
        sum  = sum - signed'(term);
        term = ((term * x2) >> 30) / 64'd156;
        sum  = sum + signed'(term);
        if (sum < 0)
            sum = 64'sd0;
        if (sum > 64'sd1073741824)
            sum = 64'sd1073741824;
        r = (unsigned'(sum) * 64'd32767 + 64'd536870912) >> 30;
        if (r > 64'd32767)
            r = 64'd32767;
        return r[AMP_W-1:0];
    endfunction

    // Entry DEPTH is only reached on odd quadrants at k = 0
    localparam amp_t TOP_ENTRY = sine_entry(64'(DEPTH));

    amp_t           rom_tbl [DEPTH];
    logic [K_W-1:0] k;
    logic           odd_q;
    logic [K_W-1:0] addr;
    amp_t           mag_next;
    amp_t           mag_reg;
    logic           neg_reg;

    for (genvar g = 0; g < DEPTH; g++)
    begin : g_tbl
        assign rom_tbl[g] = sine_entry(64'(g));
    end

    assign k     = idx[K_W-1:0];
    assign odd_q = idx[K_W];
    assign addr  = odd_q ? (~k + K_W'(1)) : k;

    always_comb
    begin
        if (odd_q && (k == '0))
            mag_next = TOP_ENTRY;
        else
            mag_next = rom_tbl[addr];
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            mag_reg <= mag_next;
            neg_reg <= idx[K_W+1];
        end
    end

    assign mag = mag_reg;
    assign neg = neg_reg;

endmodule

`default_nettype wire

FILE: src/sine_tone_burst_generator.sv
// Sine tone burst generator: one input item per audio sample tick, one result item
// back for each. A start_req item begins a burst of burst_samples samples, a tone or,
// with silent set, all zeros. The tone comes from a phase accumulator (PHASE_BITS wide,
// cleared at each start) that addresses a quarter-wave sine table of SINE_TABLE_DEPTH
// entries, which must be a power of two. The sine value is scaled by volume (Q1.15) and
// by a linear fade envelope (Q16, built from fade_gain) and truncated toward zero,
// saturating at +/-32767. Each item passes through ST_ENV, ST_MAGVOL, ST_SCALE and
// ST_DONE: the envelope product, the magnitude times volume and the final scaling all
// go through one shared 31x17 multiplier, one use per cycle, and the result is loaded
// into the output register in ST_DONE, in the same cycle the next item may be accepted.
// in_stall is high while an item is in work and while a finished result can not yet
// leave because the previous one is still stalled. Config registers are written through
// cfg_valid/cfg_ready (always ready); write them only while the block is idle. Unknown
// indexes are ignored. Depends on stbg_pkg and stbg_sine_rom.
`timescale 1ns / 1ps
`default_nettype none

module sine_tone_burst_generator
    import stbg_pkg::*;
#(
    parameter int SINE_TABLE_DEPTH = 256,
    parameter int PHASE_BITS       = 32
)
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    // input item channel
    input  wire logic                  in_valid,
    output logic                       in_stall,
    input  wire logic                  start_req,
    input  wire logic                  silent,
    // result item channel
    output logic                       out_valid,
    input  wire logic                  out_stall,
    output logic signed [SAMPLE_W-1:0] sample,
    output logic                       active,
    output logic                       last,
    // config write channel
    input  wire logic                  cfg_valid,
    output logic                       cfg_ready,
    input  wire logic [CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [CFG_DATA_W-1:0] cfg_data
);

    localparam int IDX_W   = $clog2(SINE_TABLE_DEPTH) + 2;  // quadrant + table index
    localparam int MUL_A_W = 31;
    localparam int MUL_B_W = 17;
    localparam int MUL_P_W = MUL_A_W + MUL_B_W;

    localparam logic [MUL_B_W-1:0] ENV_ONE = 17'h10000;

    // Sequencer states
    localparam logic [2:0] ST_IDLE   = 3'd0;
    localparam logic [2:0] ST_ENV    = 3'd1;  // factor * fade_gain, table read
    localparam logic [2:0] ST_MAGVOL = 3'd2;  // |sine| * volume
    localparam logic [2:0] ST_SCALE  = 3'd3;  // (|sine| * volume) * envelope
    localparam logic [2:0] ST_DONE   = 3'd4;  // saturate, sign, load output

    // Envelope modes
    localparam logic [1:0] ENV_FULL   = 2'd0;
    localparam logic [1:0] ENV_ZERO   = 2'd1;
    localparam logic [1:0] ENV_SCALED = 2'd2;

    // ---------------- config registers ----------------
    logic [30:0] phase_step_reg;
    logic [15:0] burst_samples_reg;
    logic [15:0] fade_samples_reg;
    logic [16:0] fade_gain_reg;
    logic [15:0] volume_reg;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_step_reg    <= 31'd50935781;
            burst_samples_reg <= 16'd6615;
            fade_samples_reg  <= 16'd441;
            fade_gain_reg     <= 17'd149;
            volume_reg        <= 16'd29491;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                REG_PHASE_STEP:    phase_step_reg    <= cfg_data;
                REG_BURST_SAMPLES: burst_samples_reg <= cfg_data[15:0];
                REG_FADE_SAMPLES:  fade_samples_reg  <= cfg_data[15:0];
                REG_FADE_GAIN:     fade_gain_reg     <= cfg_data[16:0];
                REG_VOLUME:        volume_reg        <= cfg_data[15:0];
                default:           ;
            endcase
        end
    end

    // ---------------- burst state and sequencer ----------------
    logic [2:0]            state_reg,   state_next;
    logic [15:0]           idx_reg,     idx_next;
    logic [PHASE_BITS-1:0] phase_reg,   phase_next;
    logic                  running_reg, running_next;
    logic                  silent_reg,  silent_next;
    logic                  out_valid_reg, out_valid_next;

    // per-item work registers
    logic [15:0]        w_idx_reg;
    logic [IDX_W-1:0]   w_rom_idx_reg;
    logic               w_run_reg;
    logic               w_tone_reg;
    logic               w_last_reg;
    logic [1:0]         env_mode_reg, env_mode_next;
    logic [MUL_B_W-1:0] env_reg,      env_next;
    logic [MUL_P_W-1:0] mul_reg;

    logic signed [SAMPLE_W-1:0] sample_reg, sample_next;
    logic                       active_reg;
    logic                       last_reg;

    logic                  out_free;
    logic                  accept;
    logic                  load_out;
    logic [15:0]           eff_idx;
    logic [PHASE_BITS-1:0] eff_phase;
    logic                  eff_silent;
    logic                  eff_run;
    logic                  eff_last;
    logic [PHASE_BITS-1:0] step_ext;

    assign out_free = !out_valid_reg || !out_stall;
    assign in_stall = !((state_reg == ST_IDLE) || ((state_reg == ST_DONE) && out_free));
    assign accept   = in_valid && !in_stall;
    assign load_out = (state_reg == ST_DONE) && out_free;
    assign step_ext = PHASE_BITS'(phase_step_reg);

    // A start restarts the burst before this tick's sample is produced
    always_comb
    begin
        eff_idx    = start_req ? 16'd0 : idx_reg;
        eff_phase  = start_req ? '0 : phase_reg;
        eff_silent = start_req ? silent : silent_reg;
        eff_run    = start_req ? (burst_samples_reg != 16'd0) : running_reg;
        eff_last   = eff_run && (({1'b0, eff_idx} + 17'd1) >= {1'b0, burst_samples_reg});
    end

    always_comb
    begin
        state_next   = state_reg;
        idx_next     = idx_reg;
        phase_next   = phase_reg;
        running_next = running_reg;
        silent_next  = silent_reg;

        if (accept)
        begin
            silent_next  = eff_silent;
            idx_next     = eff_run ? (eff_idx + 16'd1) : eff_idx;
            phase_next   = eff_run ? (eff_phase + step_ext) : eff_phase;
            running_next = eff_run && !eff_last;
        end

        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                    state_next = ST_ENV;
            end
            ST_ENV:    state_next = ST_MAGVOL;
            ST_MAGVOL: state_next = ST_SCALE;
            ST_SCALE:  state_next = ST_DONE;
            ST_DONE:
            begin
                if (accept)
                    state_next = ST_ENV;
                else if (out_free)
                    state_next = ST_IDLE;
            end
            default:   state_next = ST_IDLE;
        endcase
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (load_out)
            out_valid_next = 1'b1;
        else if (out_valid_reg && !out_stall)
            out_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            idx_reg       <= 16'd0;
            phase_reg     <= '0;
            running_reg   <= 1'b0;
            silent_reg    <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            idx_reg       <= idx_next;
            phase_reg     <= phase_next;
            running_reg   <= running_next;
            silent_reg    <= silent_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // ---------------- envelope selection ----------------
    logic        i_ge_n;
    logic        fade_out;
    logic        fade_in;
    logic [15:0] env_factor;

    always_comb
    begin
        i_ge_n   = w_idx_reg >= burst_samples_reg;
        // fade out only exists when the fade fits in the burst
        fade_out = (fade_samples_reg <= burst_samples_reg) &&
                   (w_idx_reg >= (burst_samples_reg - fade_samples_reg));
        fade_in  = w_idx_reg < fade_samples_reg;

        priority if (i_ge_n)
            env_mode_next = ENV_ZERO;
        else if (fade_out || fade_in)
            env_mode_next = ENV_SCALED;
        else
            env_mode_next = ENV_FULL;

        // fade out wins over fade in
        if (fade_out && !i_ge_n)
            env_factor = burst_samples_reg - 16'd1 - w_idx_reg;
        else
            env_factor = w_idx_reg;
    end

    always_comb
    begin
        unique case (env_mode_reg)
            ENV_ZERO:   env_next = '0;
            ENV_SCALED: env_next = (mul_reg[32:0] > 33'h10000) ? ENV_ONE : mul_reg[16:0];
            default:    env_next = ENV_ONE;
        endcase
    end

    // ---------------- sine table ----------------
    amp_t rom_mag;
    logic rom_neg;

    stbg_sine_rom #(
        .DEPTH (SINE_TABLE_DEPTH)
    ) u_rom (
        .clk   (clk),
        .rd_en (state_reg == ST_ENV),
        .idx   (w_rom_idx_reg),
        .mag   (rom_mag),
        .neg   (rom_neg)
    );

    // ---------------- shared multiplier ----------------
    logic [MUL_A_W-1:0] mul_a;
    logic [MUL_B_W-1:0] mul_b;
    logic [MUL_P_W-1:0] mul_p;

    always_comb
    begin
        unique case (state_reg)
            ST_ENV:
            begin
                mul_a = MUL_A_W'(env_factor);
                mul_b = fade_gain_reg;
            end
            ST_MAGVOL:
            begin
                mul_a = MUL_A_W'(rom_mag);
                mul_b = MUL_B_W'(volume_reg);
            end
            ST_SCALE:
            begin
                mul_a = mul_reg[MUL_A_W-1:0];
                mul_b = env_reg;
            end
            default:
            begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    assign mul_p = MUL_P_W'(mul_a) * MUL_P_W'(mul_b);

    // ---------------- result formatting ----------------
    logic [16:0] prod_top;
    amp_t        mag_sat;

    always_comb
    begin
        prod_top = mul_reg[MUL_P_W-1:31];
        mag_sat  = (prod_top > 17'(AMP_MAX)) ? AMP_MAX : prod_top[AMP_W-1:0];
        if (!w_tone_reg)
            sample_next = '0;
        else if (rom_neg)
            sample_next = -signed'({1'b0, mag_sat});
        else
            sample_next = signed'({1'b0, mag_sat});
    end

    // datapath registers, no reset
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            w_idx_reg     <= eff_idx;
            w_rom_idx_reg <= eff_phase[PHASE_BITS-1 -: IDX_W];
            w_run_reg     <= eff_run;
            w_tone_reg    <= eff_run && !eff_silent;
            w_last_reg    <= eff_last;
        end
        if (state_reg == ST_ENV)
            env_mode_reg <= env_mode_next;
        if (state_reg == ST_MAGVOL)
            env_reg <= env_next;
        if ((state_reg == ST_ENV) || (state_reg == ST_MAGVOL) || (state_reg == ST_SCALE))
            mul_reg <= mul_p;
        if (load_out)
        begin
            sample_reg <= sample_next;
            active_reg <= w_run_reg;
            last_reg   <= w_last_reg;
        end
    end

    assign out_valid = out_valid_reg;
    assign sample    = sample_reg;
    assign active    = active_reg;
    assign last      = last_reg;

endmodule

`default_nettype wire

FILE: src/stbg_checker.sv
// Port-level checks for sine_tone_burst_generator, bound to the top level.
// Depends on sine_tone_burst_generator_assert.svh.
`timescale 1ns / 1ps
`default_nettype none

`include "sine_tone_burst_generator_assert.svh"

module stbg_checker
(
    input wire logic        clk,
    input wire logic        rst_n,
    input wire logic        in_valid,
    input wire logic        in_stall,
    input wire logic        out_valid,
    input wire logic        out_stall,
    input wire logic [15:0] sample,
    input wire logic        active,
    input wire logic        last
);

    // stalled result holds
    `STBG_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid && $stable(sample) && $stable(active) && $stable(last))

    // idle ticks give silence and no end marker
    `STBG_ASSERT_NOW(a_idle_zero, out_valid && !active, (sample == 16'h0000) && !last)

    // magnitude saturates symmetrically
    `STBG_ASSERT_NOW(a_no_min, out_valid, sample != 16'h8000)

    // an accepted item keeps the block busy the next cycle
    `STBG_ASSERT_NEXT(a_busy_after_accept, in_valid && !in_stall, in_stall)

endmodule

bind sine_tone_burst_generator stbg_checker u_stbg_checker (.*);

`default_nettype wire

FILE: test/testbench.sv
// Self-checking bench for sine_tone_burst_generator: directed ticks, then random bursts.
// Holds its own bit-true predictor of the tone, fade envelope and burst framing.
// Depends on stbg_pkg and the generator RTL under src.
`timescale 1ns / 1ps

module testbench
    import stbg_pkg::*;
();

    localparam int CLK_PERIOD      = 8;
    localparam int RESET_CYCLES    = 9;
    localparam int CYCLE_LIMIT     = 200000;  // far above the slowest legal run
    localparam int SETTLE_CYCLES   = 8;       // settle time after the queue empties
    localparam int RANDOM_PHASES   = 9;
    localparam int ITEMS_PER_PHASE = 44;
    localparam int TABLE_DEPTH     = 256;

    // Indexes that map to no register; writes there must change nothing
    localparam logic [CFG_IDX_W-1:0] REG_SPARE_LO = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_SPARE_HI = 3'd7;

    // Reset values of the register file
    localparam logic [30:0] RST_PHASE_STEP = 31'd50935781;
    localparam logic [15:0] RST_BURST      = 16'd6615;
    localparam logic [15:0] RST_FADE       = 16'd441;
    localparam logic [16:0] RST_FADE_GAIN  = 17'd149;
    localparam logic [15:0] RST_VOLUME     = 16'd29491;

    typedef longint unsigned u64_t;
    typedef longint          s64_t;

    localparam u64_t HALF_PI_Q30 = 64'd1686629713;

    // Gap profiles for the two channels
    typedef enum int {GAPS_RECV_HEAVY, GAPS_SEND_HEAVY, GAPS_NONE} gap_mode_t;

    typedef struct {
        logic signed [SAMPLE_W-1:0] sample;
        logic                       active;
        logic                       last;
    } tone_result_t;

    // ------------------------------------------------------------------
    // Scoreboard: predicts one result per accepted tick and checks the
    // results in order as they leave the block.
    // ------------------------------------------------------------------
    class tone_scoreboard;
        int           errors;
        tone_result_t pending_q[$];
        int unsigned  sine_rom[TABLE_DEPTH+1];

        // register copy
        logic [30:0]  phase_step;
        logic [15:0]  burst_len;
        logic [15:0]  fade_len;
        logic [16:0]  fade_gain;
        logic [15:0]  volume;

        // burst state
        logic [15:0]  idx;
        logic [31:0]  phase;
        bit           running;
        bit           quiet;

        function new();
            u64_t k;
            errors = 0;
            for (k = 0; k <= TABLE_DEPTH; k++)
                sine_rom[k] = rom_entry(k);
            phase_step = RST_PHASE_STEP;
            burst_len  = RST_BURST;
            fade_len   = RST_FADE;
            fade_gain  = RST_FADE_GAIN;
            volume     = RST_VOLUME;
            idx        = '0;
            phase      = '0;
            running    = 1'b0;
            quiet      = 1'b0;
        endfunction

        // Quarter-wave entry: Q30 Taylor series through x^13, rounded half up
        function int unsigned rom_entry(u64_t k);
            u64_t x, x2, term, r, n;
            s64_t acc;
            x    = (k * HALF_PI_Q30) / TABLE_DEPTH;
            x2   = (x * x) >> 30;
            term = x;
            acc  = s64_t'(x);
            for (n = 1; n <= 6; n++)
            begin
                term = ((term * x2) >> 30) / ((2 * n) * (2 * n + 1));
                if (n[0])
                    acc = acc - s64_t'(term);
                else
                    acc = acc + s64_t'(term);
            end
            if (acc < 0)
                acc = 0;
            if (acc > (s64_t'(1) << 30))
                acc = s64_t'(1) << 30;
            r = (u64_t'(acc) * 32767 + (u64_t'(1) << 29)) >> 30;
            if (r > 32767)
                r = 32767;
            return r[31:0];
        endfunction

        // Top 10 phase bits pick quadrant and table slot
        function int sine_value(logic [31:0] ph);
            logic [1:0] quad;
            logic [7:0] slot;
            int         v;
            quad = ph[31:30];
            slot = ph[29:22];
            v = quad[0] ? int'(sine_rom[TABLE_DEPTH - slot]) : int'(sine_rom[slot]);
            return quad[1] ? -v : v;
        endfunction

        // Q16 fade envelope; fade-out only when the fade fits in the burst
        function u64_t envelope(logic [15:0] i);
            u64_t        env;
            int unsigned n, f, ii;
            n   = 32'(burst_len);
            f   = 32'(fade_len);
            ii  = 32'(i);
            env = 65536;
            if (ii < f)
                env = u64_t'(ii) * fade_gain;
            if (ii >= n)
                env = 0;
            else if (f <= n && ii >= n - f)
                env = u64_t'(n - 1 - ii) * fade_gain;
            if (env > 65536)
                env = 65536;
            return env;
        endfunction

        function void set_reg(logic [CFG_IDX_W-1:0] index, logic [CFG_DATA_W-1:0] data);
            case (index)
                REG_PHASE_STEP:    phase_step = data;
                REG_BURST_SAMPLES: burst_len  = data[15:0];
                REG_FADE_SAMPLES:  fade_len   = data[15:0];
                REG_FADE_GAIN:     fade_gain  = data[16:0];
                REG_VOLUME:        volume     = data[15:0];
                default: ;
            endcase
        endfunction

        // One accepted tick: advance the burst and queue the sample it gives
        function void note_tick(bit start, bit sil);
            tone_result_t res;
            int           s;
            int           v;
            u64_t         mag, p;
            int unsigned  i;
            if (start)
            begin
                idx     = '0;
                phase   = '0;
                quiet   = sil;
                running = (burst_len != 0);
            end
            res.sample = '0;
            res.active = 1'b0;
            res.last   = 1'b0;
            if (running)
            begin
                i          = 32'(idx);
                res.active = 1'b1;
                res.last   = (i + 1 >= burst_len);
                if (!quiet)
                begin
                    s   = sine_value(phase);
                    mag = u64_t'((s < 0) ? -s : s);
                    p   = (mag * volume * envelope(idx)) >> 31;
                    if (p > 32767)
                        p = 32767;
                    v = int'(p);
                    if (s < 0)
                        v = -v;
                    res.sample = v[15:0];
                end
                idx   = idx + 1'b1;
                phase = phase + phase_step;
                if (res.last)
                    running = 1'b0;
            end
            pending_q.push_back(res);
        endfunction

        task report_mismatch(string msg);
            $display("mismatch: %s", msg);
            errors++;
        endtask

        task check_sample(logic signed [SAMPLE_W-1:0] s, logic a, logic l);
            tone_result_t want;
            if (pending_q.size() == 0)
            begin
                report_mismatch($sformatf("unexpected item sample=%0d active=%0b last=%0b",
                                          s, a, l));
                return;
            end
            want = pending_q.pop_front();
            if (s !== want.sample)
                report_mismatch($sformatf("sample got %0d want %0d", s, want.sample));
            if (a !== want.active)
                report_mismatch($sformatf("active got %0b want %0b", a, want.active));
            if (l !== want.last)
                report_mismatch($sformatf("last got %0b want %0b", l, want.last));
        endtask
    endclass

    // ------------------------------------------------------------------
    // DUT hookup
    // ------------------------------------------------------------------
    logic                       clk;
    logic                       rst_n;
    logic                       in_valid;
    logic                       in_stall;
    logic                       start_req;
    logic                       silent;
    logic                       out_valid;
    logic                       out_stall;
    logic signed [SAMPLE_W-1:0] sample;
    logic                       active;
    logic                       last;
    logic                       cfg_valid;
    logic                       cfg_ready;
    logic [CFG_IDX_W-1:0]       cfg_index;
    logic [CFG_DATA_W-1:0]      cfg_data;

    tone_scoreboard sb;
    int             send_idle_pct;
    int             recv_idle_pct;
    int             cycle_count;

    sine_tone_burst_generator u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .start_req (start_req),
        .silent    (silent),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .sample    (sample),
        .active    (active),
        .last      (last),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #(CLK_PERIOD / 2) clk = ~clk;
    end

    // Watchdog: a hung handshake ends the run here
    initial
    begin
        cycle_count = 0;
        while (cycle_count < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

    // Receiver: stall is redrawn every cycle, whether or not an item is waiting
    initial
    begin
        out_stall = 1'b0;
        forever
        begin
            @(negedge clk);
            out_stall <= ($urandom_range(0, 99) < recv_idle_pct);
        end
    end

    // Result monitor: every item that leaves is checked against the oldest prediction
    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
            sb.check_sample(sample, active, last);
    end

    function automatic void set_gaps(gap_mode_t mode);
        case (mode)
            GAPS_RECV_HEAVY:
            begin
                send_idle_pct = 18;
                recv_idle_pct = 57;
            end
            GAPS_SEND_HEAVY:
            begin
                send_idle_pct = 57;
                recv_idle_pct = 18;
            end
            default:
            begin
                send_idle_pct = 0;
                recv_idle_pct = 0;
            end
        endcase
    endfunction

    // Present one tick item, with random idle cycles ahead of it. Valid stays high
    // after acceptance so back-to-back items see no bubble; the next call or the
    // drain decides what happens at the following falling edge.
    task automatic send_tick(input bit start, input bit sil);
        @(negedge clk);
        while ($urandom_range(0, 99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_valid  <= 1'b1;
        start_req <= start;
        silent    <= sil;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        sb.note_tick(start, sil);
    endtask

    // Stop sending and wait for every predicted sample to come back
    task automatic drain_results();
        @(negedge clk);
        in_valid <= 1'b0;
        while (sb.pending_q.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] index,
                             input logic [CFG_DATA_W-1:0] data);
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= index;
        cfg_data  <= data;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        sb.set_reg(index, data);
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    task automatic program_tone(input logic [30:0] step, input logic [30:0] burst,
                                input logic [30:0] fade, input logic [30:0] gain,
                                input logic [30:0] vol);
        write_reg(REG_PHASE_STEP, step);
        write_reg(REG_BURST_SAMPLES, burst);
        write_reg(REG_FADE_SAMPLES, fade);
        write_reg(REG_FADE_GAIN, gain);
        write_reg(REG_VOLUME, vol);
    endtask

    // Mostly short bursts so that fade-in, fade-out and last all come around often;
    // a few phases pin the register extremes.
    task automatic program_random(input int phase_no);
        logic [30:0] step, burst, fade, gain, vol;
        step  = 31'($urandom);
        burst = 31'($urandom_range(1, 24));
        fade  = 31'($urandom_range(0, burst + 4));
        gain  = 31'((fade == 0) ? $urandom_range(0, 65536) : 65536 / fade);
        if ($urandom_range(0, 3) == 0)
            gain = 31'($urandom_range(0, 65536));
        vol = 31'($urandom_range(0, 32768));
        case (phase_no)
            0:
            begin
                step = '0;
                vol  = 31'd32768;
                gain = 31'd65536;
            end
            1:
            begin
                step = 31'h7FFF_FFFF;
                vol  = '0;
            end
            2:
            begin
                burst = 31'd1;
                fade  = '0;
            end
            3:
            begin
                // fade as long as the burst: fade-out covers it from the first sample
                burst = 31'd65535;
                fade  = 31'd65535;
                gain  = 31'd1;
            end
            4:
            begin
                // full-width gains, junk above the burst field
                vol   = 31'd65535;
                gain  = 31'd131071;
                burst = burst | (31'($urandom_range(1, 32767)) << 16);
            end
            default: ;
        endcase
        program_tone(step, burst, fade, gain, vol);
        if (phase_no % 2 == 1)
            write_reg(REG_SPARE_LO, 31'($urandom));
        if (phase_no == 4)
            write_reg(REG_SPARE_HI, 31'($urandom));
    endtask

    // Mostly well-formed traffic: start when idle, let bursts finish, rarely restart.
    // One item in ten is pure noise.
    task automatic run_random_ticks(input int count);
        bit start, sil;
        repeat (count)
        begin
            if ($urandom_range(0, 9) == 0)
            begin
                start = 1'($urandom_range(0, 1));
                sil   = 1'($urandom_range(0, 1));
            end
            else if (!sb.running)
            begin
                start = ($urandom_range(0, 9) < 7);
                sil   = ($urandom_range(0, 3) == 0);
            end
            else
            begin
                start = ($urandom_range(0, 99) < 4);
                sil   = 1'($urandom_range(0, 1));
            end
            send_tick(start, sil);
        end
    endtask

    initial
    begin
        sb        = new();
        rst_n     = 1'b0;
        in_valid  = 1'b0;
        start_req = 1'b0;
        silent    = 1'b0;
        cfg_valid = 1'b0;
        cfg_index = '0;
        cfg_data  = '0;
        set_gaps(GAPS_RECV_HEAVY);
        repeat (RESET_CYCLES) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        repeat (2) @(posedge clk);

        // Directed: idle ticks, a tone burst with saturating volume, restart mid-burst
        program_tone(31'h2000_0000, 31'd5, 31'd2, 31'd32768, 31'd65535);
        send_tick(1'b0, 1'b0);
        send_tick(1'b0, 1'b1);   // silent without start is ignored
        send_tick(1'b1, 1'b0);
        repeat (2) send_tick(1'b0, 1'b0);
        send_tick(1'b1, 1'b0);   // restart at sample zero
        repeat (4) send_tick(1'b0, 1'b0);
        send_tick(1'b0, 1'b0);   // back to idle
        drain_results();

        // Zero-length burst: start gives nothing and the block stays idle
        write_reg(REG_BURST_SAMPLES, 31'd0);
        send_tick(1'b1, 1'b0);
        send_tick(1'b1, 1'b1);
        send_tick(1'b0, 1'b0);
        drain_results();

        // Fade longer than burst, then shrink the burst under a running one
        program_tone(31'h0400_0000, 31'd8, 31'd10, 31'd65536, 31'd32768);
        send_tick(1'b1, 1'b0);
        repeat (3) send_tick(1'b0, 1'b0);
        drain_results();
        write_reg(REG_BURST_SAMPLES, 31'd2);
        send_tick(1'b0, 1'b0);   // index past the new length: zero envelope, last
        send_tick(1'b0, 1'b0);
        drain_results();

        // Zero fade length, silent burst followed by a tone burst
        program_tone(31'h0B00_0000, 31'd3, 31'd0, 31'd0, 31'd20000);
        send_tick(1'b1, 1'b1);
        repeat (2) send_tick(1'b0, 1'b0);
        send_tick(1'b1, 1'b0);
        send_tick(1'b0, 1'b0);
        drain_results();

        // Random phases: receiver-heavy gaps, then sender-heavy, then none
        for (int phase_no = 0; phase_no < RANDOM_PHASES; phase_no++)
        begin
            set_gaps(gap_mode_t'(phase_no / 3));
            program_random(phase_no);
            run_random_ticks(ITEMS_PER_PHASE);
            drain_results();
        end

        if (sb.errors == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule

FILE: sim.f
+incdir+src
src/stbg_pkg.sv
src/stbg_sine_rom.sv
src/sine_tone_burst_generator.sv
src/stbg_checker.sv
test/testbench.sv
